[sv/elo_pkg.sv]
// ---------------------------------------------------------------------------
// Elo rating update package
// Shared types, operation and register codes, and the constant functions that
// build the logistic table at elaboration.
// ---------------------------------------------------------------------------
package elo_pkg;

   localparam int PERSON_INDEX_W = 8;
   localparam int ITEM_INDEX_W   = 10;
   localparam int GAIN_W         = 12;
   localparam int EXPECT_W       = 13;

   typedef logic signed [15:0]      rating_type;
   typedef logic [GAIN_W-1:0]       gain_type;
   typedef logic [EXPECT_W-1:0]     expect_type;
   typedef logic [1:0]              op_code_type;

   localparam op_code_type OP_UPDATE      = 2'd0;
   localparam op_code_type OP_LOAD_PERSON = 2'd1;
   localparam op_code_type OP_LOAD_ITEM   = 2'd2;

   localparam logic REG_STUDENT_GAIN = 1'b0;
   localparam logic REG_ITEM_GAIN    = 1'b1;

   localparam gain_type GAIN_RESET = 12'd410;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_INDEX,
      S_READ,
      S_DIFF,
      S_LOOK,
      S_MUL,
      S_WB
   } state_type;

   localparam logic [63:0] Q62_ONE = 64'd1 << 62;

   // Product of two Q62 fractions not above one, truncated to Q62.
   function automatic logic [63:0] mul_q62(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] xl, xh, yl, yh, ll, lh, hl, hh, mid, lo, hi;
      xl  = {32'd0, x[31:0]};
      xh  = {32'd0, x[63:32]};
      yl  = {32'd0, y[31:0]};
      yh  = {32'd0, y[63:32]};
      ll  = xl * yl;
      lh  = xl * yh;
      hl  = xh * yl;
      hh  = xh * yh;
      mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
      lo  = {mid[31:0], ll[31:0]};
      hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
      return (hi << 2) | (lo >> 62);
   endfunction

   // exp(-a/4096) in Q62: a short series at a/2^24, then twelve squarings.
   function automatic logic [63:0] exp_neg_q62(input logic [31:0] a);
      logic [63:0] t, t2, t3, t4, s;
      t  = 64'(a) << 38;
      t2 = mul_q62(t, t);
      t3 = mul_q62(t2, t);
      t4 = mul_q62(t3, t);
      s  = Q62_ONE - t + t2 / 64'd2 - t3 / 64'd6 + t4 / 64'd24;
      for (int n = 0; n < 12; n++) begin
         s = mul_q62(s, s);
      end
      return s;
   endfunction

   // Restoring long division, used only while the table is built.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Logistic of z/4096 rounded to Q0.12; negative points mirror positive ones.
   function automatic expect_type logistic_q12(input int z);
      logic [31:0] a;
      logic [63:0] e40, den, num, v;
      a   = (z < 0) ? 32'(-z) : 32'(z);
      e40 = exp_neg_q62(a) >> 22;
      den = (64'd1 << 40) + e40;
      num = 64'd4096 << 40;
      v   = udiv64(num + (den >> 1), den);
      return (z < 0) ? EXPECT_W'(64'd4096 - v) : EXPECT_W'(v);
   endfunction

endpackage

[sv/elo_req_if.sv]
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operation item into the block.
// ---------------------------------------------------------------------------
interface elo_req_if import elo_pkg::*; ();

   logic                      valid;
   logic                      ready;
   op_code_type               operation;
   logic [PERSON_INDEX_W-1:0] person_index;
   logic [ITEM_INDEX_W-1:0]   item_index;
   logic                      response;
   rating_type                load_value;

   modport source (
      output valid, operation, person_index, item_index, response, load_value,
      input  ready
   );

   modport sink (
      input  valid, operation, person_index, item_index, response, load_value,
      output ready
   );

endinterface

[sv/elo_rsp_if.sv]
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item out of the block.
// ---------------------------------------------------------------------------
interface elo_rsp_if import elo_pkg::*; ();

   logic       valid;
   logic       ready;
   rating_type person_rating;
   rating_type item_rating;
   expect_type expected_correct;
   logic       saturated;

   modport source (
      output valid, person_rating, item_rating, expected_correct, saturated,
      input  ready
   );

   modport sink (
      input  valid, person_rating, item_rating, expected_correct, saturated,
      output ready
   );

endinterface

[sv/elo_rating_ram.sv]
// ---------------------------------------------------------------------------
// Rating memory
// Synchronous memory of Q4.12 ratings with one write port and one registered read port.
// ---------------------------------------------------------------------------
module elo_rating_ram import elo_pkg::*; #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output rating_type               rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  rating_type               wr_data
);

   rating_type mem [DEPTH];
   rating_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/elo_logistic_rom.sv]
// ---------------------------------------------------------------------------
// Logistic table
// Constant table of expected correctness, built at elaboration, with a
// registered read.
// ---------------------------------------------------------------------------
module elo_logistic_rom import elo_pkg::*; #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   output expect_type               data
);

   expect_type lut [DEPTH];
   expect_type data_ff;

   // Each entry is evaluated at the centre of its slice of the difference range.
   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      localparam longint ZL = -64'sd32768 +
                              ((2 * longint'(g) + 1) * 64'sd32768) / DEPTH;
      localparam expect_type VAL = logistic_q12(int'(ZL));
      assign lut[g] = VAL;
   end

   always_ff @(posedge clock) begin
      data_ff <= lut[addr];
   end

   assign data = data_ff;

endmodule

[sv/elo_index_mod.sv]
// ---------------------------------------------------------------------------
// Index reduction
// Reduces an index modulo the table depth by a reciprocal multiply, with the
// quotient registered before the correcting subtract.
// ---------------------------------------------------------------------------
module elo_index_mod import elo_pkg::*; #(
   parameter int unsigned W = 8,
   parameter int unsigned N = 256
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic [W-1:0]         x_in,
   output logic [$clog2(N)-1:0] r_out
);

   // floor(2^2W / N) underestimates the quotient by at most one.
   localparam int unsigned RP = (2 ** (2 * W)) / N;

   logic [W-1:0]   x_ff;
   logic [W-1:0]   q_ff;
   logic [3*W-1:0] prod;
   logic [W-1:0]   qn;
   logic [W:0]     rem;
   logic [W:0]     red;

   assign prod = (3 * W)'(x_in * RP);

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_in;
         q_ff <= prod[3*W-1:2*W];
      end
   end

   always_comb begin
      qn  = W'(q_ff * N);
      rem = {1'b0, x_ff} - {1'b0, qn};
      red = (rem >= N) ? (W + 1)'(rem - N) : rem;
   end

   assign r_out = $clog2(N)'(red);

endmodule

[sv/elo_rating_update.sv]
// ---------------------------------------------------------------------------
// Elo rating update
// Person and item rating tables with logistic expected correctness and a
// gain-scaled rating update per response.
// ---------------------------------------------------------------------------
// One item is in flight at a time and goes from acceptance to a registered
// result through these steps: the accept, index reduction, the rating memory
// read, the rating difference and table index, the logistic table read, the
// gain multiply and the write-back. The sequence is set by the single read
// port of each rating memory and the read-modify-write through it, so the
// next item is read only after the previous one is written back. The result
// waits in an output register while the next item is accepted; write-back
// stalls only while that register is still full. After reset a clearing pass
// writes zero to both rating memories, over the larger of the two depths,
// during which no item is accepted. Gains are to be written through the csr
// port only while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module elo_rating_update import elo_pkg::*; #(
   parameter int unsigned NUM_PERSONS          = 256,
   parameter int unsigned NUM_ITEMS            = 1024,
   parameter int unsigned LOGISTIC_TABLE_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_index,
   input  gain_type     csr_wdata,
   elo_req_if.sink      req_chan,
   elo_rsp_if.source    rsp_chan
);

   localparam int PAW       = $clog2(NUM_PERSONS);
   localparam int IAW       = $clog2(NUM_ITEMS);
   localparam int KW        = $clog2(LOGISTIC_TABLE_DEPTH);
   localparam int CLR_DEPTH = (NUM_PERSONS > NUM_ITEMS) ? NUM_PERSONS : NUM_ITEMS;
   localparam int CW        = $clog2(CLR_DEPTH);

   state_type   state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic        clr_done;

   gain_type    student_gain_ff, item_gain_ff;

   op_code_type op_ff;
   logic        resp_ff;
   rating_type  load_ff;
   logic [PAW-1:0] pidx_ff;
   logic [IAW-1:0] iidx_ff;
   logic [PAW-1:0] pidx_red;
   logic [IAW-1:0] iidx_red;
   logic [KW-1:0]  k_ff, k_in;

   logic signed [26:0] pprod_ff, pprod_in, iprod_ff, iprod_in;

   logic        accept, ram_rd, wb_fire, clearing;
   rating_type  pr, ir;
   expect_type  expect_q;

   logic        p_we, i_we;
   logic [PAW-1:0] p_waddr;
   logic [IAW-1:0] i_waddr;
   rating_type  p_wdata, i_wdata;

   logic        rsp_valid_ff;
   rating_type  rsp_person_ff, rsp_person_in;
   rating_type  rsp_item_ff, rsp_item_in;
   expect_type  rsp_expect_ff, rsp_expect_in;
   logic        rsp_sat_ff, rsp_sat_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         student_gain_ff <= GAIN_RESET;
         item_gain_ff    <= GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_STUDENT_GAIN: student_gain_ff <= csr_wdata;
            REG_ITEM_GAIN:    item_gain_ff    <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Sequencer.
   assign clr_done = (clr_ff == CW'(CLR_DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_done) state_in = S_IDLE;
         S_IDLE:  if (req_chan.valid) state_in = S_INDEX;
         S_INDEX: state_in = S_READ;
         S_READ:  state_in = S_DIFF;
         S_DIFF:  state_in = S_LOOK;
         S_LOOK:  state_in = S_MUL;
         S_MUL:   state_in = S_WB;
         S_WB:    if (!rsp_valid_ff || rsp_chan.ready) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      ram_rd         = 1'b0;
      wb_fire        = 1'b0;
      clearing       = 1'b0;
      case (state_ff)
         S_CLEAR: clearing       = 1'b1;
         S_IDLE:  req_chan.ready = 1'b1;
         S_READ:  ram_rd         = 1'b1;
         S_WB:    wb_fire        = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign accept = req_chan.valid && req_chan.ready;
   assign clr_in = clr_done ? clr_ff : clr_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_ff <= clr_in;
         end
      end
   end

   // Item capture and index reduction.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_chan.operation;
         resp_ff <= req_chan.response;
         load_ff <= req_chan.load_value;
      end
      if (state_ff == S_INDEX) begin
         pidx_ff <= pidx_red;
         iidx_ff <= iidx_red;
      end
   end

   elo_index_mod #(.W(PERSON_INDEX_W), .N(NUM_PERSONS)) u_pmod (
      .clock (clock),
      .load  (accept),
      .x_in  (req_chan.person_index),
      .r_out (pidx_red)
   );

   elo_index_mod #(.W(ITEM_INDEX_W), .N(NUM_ITEMS)) u_imod (
      .clock (clock),
      .load  (accept),
      .x_in  (req_chan.item_index),
      .r_out (iidx_red)
   );

   // Rating memories.
   elo_rating_ram #(.DEPTH(NUM_PERSONS)) u_pram (
      .clock   (clock),
      .rd_en   (ram_rd),
      .rd_addr (pidx_ff),
      .rd_data (pr),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata)
   );

   elo_rating_ram #(.DEPTH(NUM_ITEMS)) u_iram (
      .clock   (clock),
      .rd_en   (ram_rd),
      .rd_addr (iidx_ff),
      .rd_data (ir),
      .wr_en   (i_we),
      .wr_addr (i_waddr),
      .wr_data (i_wdata)
   );

   // Difference, clamped to the Q4.12 range, mapped onto a table index.
   always_comb begin
      logic signed [16:0] diff;
      rating_type         dc;
      logic [15:0]        u;
      logic [16+KW-1:0]   kprod;
      diff = 17'(pr) - 17'(ir);
      if (diff > 17'sd32767) begin
         dc = 16'sh7FFF;
      end else if (diff < -17'sd32768) begin
         dc = 16'sh8000;
      end else begin
         dc = diff[15:0];
      end
      u     = {~dc[15], dc[14:0]};
      kprod = (16 + KW)'(u * LOGISTIC_TABLE_DEPTH);
      k_in  = kprod[16+KW-1:16];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DIFF) begin
         k_ff <= k_in;
      end
   end

   elo_logistic_rom #(.DEPTH(LOGISTIC_TABLE_DEPTH)) u_rom (
      .clock (clock),
      .addr  (k_ff),
      .data  (expect_q)
   );

   // Error times gain.
   always_comb begin
      logic signed [13:0] err;
      err = resp_ff ? (14'sd4096 - $signed({1'b0, expect_q}))
                    : -$signed({1'b0, expect_q});
      pprod_in = $signed({1'b0, student_gain_ff}) * err;
      iprod_in = $signed({1'b0, item_gain_ff}) * err;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         pprod_ff <= pprod_in;
         iprod_ff <= iprod_in;
      end
   end

   // Write-back: round to Q4.12, apply, saturate, and form the result.
   always_comb begin
      logic signed [27:0] prnd, irnd;
      logic signed [15:0] dp, di;
      logic signed [17:0] np, ni;
      rating_type         sp, si;
      logic               sat;
      prnd = (28'(pprod_ff) + 28'sd2048) >>> 12;
      irnd = (28'(iprod_ff) + 28'sd2048) >>> 12;
      dp   = prnd[15:0];
      di   = irnd[15:0];
      np   = 18'(pr) + 18'(dp);
      ni   = 18'(ir) - 18'(di);
      sat  = 1'b0;
      if (np > 18'sd32767) begin
         sp  = 16'sh7FFF;
         sat = 1'b1;
      end else if (np < -18'sd32768) begin
         sp  = 16'sh8000;
         sat = 1'b1;
      end else begin
         sp = np[15:0];
      end
      if (ni > 18'sd32767) begin
         si  = 16'sh7FFF;
         sat = 1'b1;
      end else if (ni < -18'sd32768) begin
         si  = 16'sh8000;
         sat = 1'b1;
      end else begin
         si = ni[15:0];
      end

      p_we          = 1'b0;
      i_we          = 1'b0;
      p_waddr       = pidx_ff;
      i_waddr       = iidx_ff;
      p_wdata       = sp;
      i_wdata       = si;
      rsp_person_in = pr;
      rsp_item_in   = ir;
      rsp_expect_in = '0;
      rsp_sat_in    = 1'b0;
      case (op_ff)
         OP_UPDATE: begin
            p_we          = wb_fire;
            i_we          = wb_fire;
            rsp_person_in = sp;
            rsp_item_in   = si;
            rsp_expect_in = expect_q;
            rsp_sat_in    = sat;
         end
         OP_LOAD_PERSON: begin
            p_we          = wb_fire;
            p_wdata       = load_ff;
            rsp_person_in = load_ff;
         end
         OP_LOAD_ITEM: begin
            i_we          = wb_fire;
            i_wdata       = load_ff;
            rsp_item_in   = load_ff;
         end
         default: ;
      endcase

      // The clearing pass owns both write ports after reset.
      if (clearing) begin
         p_we    = (clr_ff < NUM_PERSONS);
         i_we    = (clr_ff < NUM_ITEMS);
         p_waddr = clr_ff[PAW-1:0];
         i_waddr = clr_ff[IAW-1:0];
         p_wdata = '0;
         i_wdata = '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (wb_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_fire) begin
         rsp_person_ff <= rsp_person_in;
         rsp_item_ff   <= rsp_item_in;
         rsp_expect_ff <= rsp_expect_in;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.person_rating    = rsp_person_ff;
   assign rsp_chan.item_rating      = rsp_item_ff;
   assign rsp_chan.expected_correct = rsp_expect_ff;
   assign rsp_chan.saturated        = rsp_sat_ff;

endmodule

[tb/tb_elo_rating_update.sv]
// ---------------------------------------------------------------------------
// Elo rating update testbench
// Drives load, update and undefined operations into the rating block, keeps
// its own copy of both rating tables, the gains and the logistic table, and
// compares every result item field by field with the predicted one. Directed
// tests cover the extremes, clamping of the difference and saturation; the
// random part runs under several gain settings and idling patterns.
// ---------------------------------------------------------------------------
module tb_elo_rating_update;
   timeunit 1ns;
   timeprecision 1ps;

   import elo_pkg::*;

   localparam int NUM_PERSONS = 256;
   localparam int NUM_ITEMS   = 1024;
   localparam int LUT_DEPTH   = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 16;
   localparam int PHASE_ITEMS = 325;
   localparam int GAIN_MAX    = 4095;

   localparam op_code_type OP_UNDEFINED = 2'd3;

   typedef struct {
      rating_type person_rating;
      rating_type item_rating;
      expect_type expected_correct;
      logic       saturated;
   } rating_outcome_type;

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_we;
   logic     csr_index;
   gain_type csr_wdata;

   elo_req_if req_chan ();
   elo_rsp_if rsp_chan ();

   elo_rating_update #(
      .NUM_PERSONS          (NUM_PERSONS),
      .NUM_ITEMS            (NUM_ITEMS),
      .LOGISTIC_TABLE_DEPTH (LUT_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   rating_type         person_table [NUM_PERSONS];
   rating_type         item_table [NUM_ITEMS];
   expect_type         logistic_lut [LUT_DEPTH];
   int                 gain_person;
   int                 gain_item;
   rating_outcome_type pending_outcomes [$];
   rating_outcome_type oldest;
   int                 fail_count = 0;
   int                 cycle_count = 0;
   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Q62 product, truncated; the operands never exceed one.
   function automatic logic [63:0] q62_mul(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return p[125:62];
   endfunction

   // exp(-a/4096) in Q62: five series terms at a/2^24, squared twelve times.
   function automatic logic [63:0] decay_q62(input logic [31:0] a);
      logic [63:0] t, t2, t3, t4, s;
      t  = {32'd0, a} << 38;
      t2 = q62_mul(t, t);
      t3 = q62_mul(t2, t);
      t4 = q62_mul(t3, t);
      s  = (64'd1 << 62) - t + t2 / 64'd2 - t3 / 64'd6 + t4 / 64'd24;
      repeat (12) s = q62_mul(s, s);
      return s;
   endfunction

   function automatic expect_type logistic_at(input int z);
      logic [31:0] a;
      logic [63:0] e40, den, v;
      a   = (z < 0) ? 32'(-z) : 32'(z);
      e40 = decay_q62(a) >> 22;
      den = (64'd1 << 40) + e40;
      v   = ((64'd4096 << 40) + den / 64'd2) / den;
      return (z < 0) ? expect_type'(64'd4096 - v) : expect_type'(v);
   endfunction

   // Returns the flag in the top bit and the clamped rating below it.
   function automatic logic [16:0] clamp16(input longint v);
      if (v > 32767) return {1'b1, 16'h7fff};
      if (v < -32768) return {1'b1, 16'h8000};
      return {1'b0, v[15:0]};
   endfunction

   function automatic rating_outcome_type rate_item(input op_code_type op,
                                                    input logic [7:0] pi,
                                                    input logic [9:0] ii,
                                                    input logic resp,
                                                    input rating_type lv);
      rating_outcome_type res;
      int                 pidx, iidx, err;
      longint             pr, ir, diff, dp, di, lut_index;
      logic [16:0]        pc, ic;
      pidx = pi % NUM_PERSONS;
      iidx = ii % NUM_ITEMS;
      res.expected_correct = '0;
      res.saturated        = 1'b0;
      case (op)
         OP_LOAD_PERSON: person_table[pidx] = lv;
         OP_LOAD_ITEM:   item_table[iidx] = lv;
         OP_UPDATE: begin
            pr   = person_table[pidx];
            ir   = item_table[iidx];
            diff = pr - ir;
            if (diff > 32767) diff = 32767;
            if (diff < -32768) diff = -32768;
            lut_index = ((diff + 32768) * LUT_DEPTH) >>> 16;
            res.expected_correct = logistic_lut[lut_index];
            err = (resp ? 4096 : 0) - int'(res.expected_correct);
            // Arithmetic shift floors, which is the rounding the block uses.
            dp = (longint'(gain_person) * err + 2048) >>> 12;
            di = (longint'(gain_item) * err + 2048) >>> 12;
            pc = clamp16(pr + dp);
            ic = clamp16(ir - di);
            person_table[pidx] = pc[15:0];
            item_table[iidx]   = ic[15:0];
            res.saturated      = pc[16] | ic[16];
         end
         default: ;
      endcase
      res.person_rating = person_table[pidx];
      res.item_rating   = item_table[iidx];
      return res;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input op_code_type op, input logic [7:0] pi,
                            input logic [9:0] ii, input logic resp,
                            input rating_type lv);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.person_index <= pi;
      req_chan.item_index   <= ii;
      req_chan.response     <= resp;
      req_chan.load_value   <= lv;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_outcomes.push_back(rate_item(op, pi, ii, resp, lv));
      @(negedge clock);
   endtask

   // Gains change only once the block has returned every outstanding item.
   task automatic write_gains(input int sg, input int ig);
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_outcomes.size() != 0) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_STUDENT_GAIN;
      csr_wdata <= gain_type'(sg);
      @(negedge clock);
      csr_index <= REG_ITEM_GAIN;
      csr_wdata <= gain_type'(ig);
      @(negedge clock);
      csr_we <= 1'b0;
      gain_person = sg;
      gain_item   = ig;
   endtask

   task automatic send_random_item();
      int          sel;
      op_code_type op;
      logic [7:0]  pi;
      logic [9:0]  ii;
      rating_type  lv;
      sel = $urandom_range(0, 99);
      if (sel < 60) op = OP_UPDATE;
      else if (sel < 78) op = OP_LOAD_PERSON;
      else if (sel < 95) op = OP_LOAD_ITEM;
      else op = OP_UNDEFINED;
      // A small pool of entries keeps updates landing on the same ratings.
      sel = $urandom_range(0, 9);
      if (sel < 5) pi = 8'($urandom_range(0, 3));
      else if (sel == 5) pi = 8'hff;
      else pi = 8'($urandom);
      sel = $urandom_range(0, 9);
      if (sel < 5) ii = 10'($urandom_range(0, 3));
      else if (sel == 5) ii = 10'h3ff;
      else ii = 10'($urandom);
      sel = $urandom_range(0, 9);
      if (sel == 0) lv = 16'sh7fff;
      else if (sel == 1) lv = 16'sh8000;
      else if (sel < 6) lv = rating_type'(int'($urandom_range(0, 16383)) - 8192);
      else lv = rating_type'($urandom);
      send_item(op, pi, ii, 1'($urandom_range(0, 1)), lv);
   endtask

   task automatic test_reset_state();
      // Untouched entries are zero, so the expectation sits just above one half.
      send_item(OP_UPDATE, 8'd0, 10'd0, 1'b1, 16'sd0);
      send_item(OP_UPDATE, 8'd0, 10'd0, 1'b0, 16'sd0);
      send_item(OP_UNDEFINED, 8'hff, 10'h3ff, 1'b1, 16'sh7fff);
   endtask

   task automatic test_loads_and_clamped_difference();
      send_item(OP_LOAD_PERSON, 8'hff, 10'h3ff, 1'b0, 16'sh7fff);
      send_item(OP_LOAD_ITEM, 8'hff, 10'h3ff, 1'b1, 16'sh8000);
      send_item(OP_UNDEFINED, 8'hff, 10'h3ff, 1'b0, 16'sd0);
      send_item(OP_UPDATE, 8'hff, 10'h3ff, 1'b1, 16'sd0);
      send_item(OP_UPDATE, 8'hff, 10'h3ff, 1'b0, 16'sd0);
      send_item(OP_LOAD_PERSON, 8'd0, 10'd0, 1'b0, 16'sh8000);
      send_item(OP_LOAD_ITEM, 8'd0, 10'd0, 1'b0, 16'sh7fff);
      send_item(OP_UPDATE, 8'd0, 10'd0, 1'b0, 16'sd0);
      send_item(OP_UPDATE, 8'd0, 10'd0, 1'b1, 16'sd0);
      send_item(OP_LOAD_PERSON, 8'haa, 10'h155, 1'b1, 16'sh5555);
      send_item(OP_LOAD_ITEM, 8'h55, 10'h2aa, 1'b0, 16'shaaaa);
   endtask

   task automatic test_saturation();
      write_gains(GAIN_MAX, GAIN_MAX);
      send_item(OP_LOAD_PERSON, 8'd1, 10'd1, 1'b0, 16'sh7fff);
      send_item(OP_LOAD_ITEM, 8'd1, 10'd1, 1'b0, 16'sh7fff);
      send_item(OP_UPDATE, 8'd1, 10'd1, 1'b1, 16'sd0);
      send_item(OP_UPDATE, 8'd1, 10'd1, 1'b0, 16'sd0);
      send_item(OP_LOAD_PERSON, 8'd2, 10'd2, 1'b0, 16'sh8000);
      send_item(OP_LOAD_ITEM, 8'd2, 10'd2, 1'b0, 16'sh8000);
      send_item(OP_UPDATE, 8'd2, 10'd2, 1'b0, 16'sd0);
      send_item(OP_UPDATE, 8'd2, 10'd2, 1'b1, 16'sd0);
   endtask

   task automatic test_gain_extremes();
      write_gains(0, 0);
      send_item(OP_UPDATE, 8'd1, 10'd1, 1'b1, 16'sd0);
      write_gains(GAIN_MAX, 0);
      send_item(OP_UPDATE, 8'd1, 10'd2, 1'b0, 16'sd0);
      write_gains(0, GAIN_MAX);
      send_item(OP_UPDATE, 8'd2, 10'd1, 1'b1, 16'sd0);
   endtask

   task automatic test_random_traffic();
      int idle_pct [4]  = '{0, 73, 0, 19};
      int stall_pct [4] = '{0, 0, 73, 19};
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 0) write_gains(GAIN_RESET, GAIN_RESET);
         else write_gains($urandom_range(0, GAIN_MAX), $urandom_range(0, GAIN_MAX));
         sender_idle_pct    = idle_pct[phase];
         receiver_stall_pct = stall_pct[phase];
         repeat (PHASE_ITEMS) send_random_item();
      end
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_elo_rating_update NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result item arrived with nothing expected", $time);
            fail_count++;
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_chan.person_rating !== oldest.person_rating) begin
               $display("%0t: person_rating expected %0d actual %0d", $time,
                        oldest.person_rating, rsp_chan.person_rating);
               fail_count++;
            end
            if (rsp_chan.item_rating !== oldest.item_rating) begin
               $display("%0t: item_rating expected %0d actual %0d", $time,
                        oldest.item_rating, rsp_chan.item_rating);
               fail_count++;
            end
            if (rsp_chan.expected_correct !== oldest.expected_correct) begin
               $display("%0t: expected_correct expected %0d actual %0d", $time,
                        oldest.expected_correct, rsp_chan.expected_correct);
               fail_count++;
            end
            if (rsp_chan.saturated !== oldest.saturated) begin
               $display("%0t: saturated expected %0b actual %0b", $time,
                        oldest.saturated, rsp_chan.saturated);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = REG_STUDENT_GAIN;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_UPDATE;
      req_chan.person_index = '0;
      req_chan.item_index   = '0;
      req_chan.response     = 1'b0;
      req_chan.load_value   = '0;
      rsp_chan.ready        = 1'b0;
      gain_person           = GAIN_RESET;
      gain_item             = GAIN_RESET;
      foreach (person_table[n]) person_table[n] = '0;
      foreach (item_table[n]) item_table[n] = '0;
      // Each entry is the logistic at the middle of its slice of the range.
      for (int k = 0; k < LUT_DEPTH; k++) begin
         logistic_lut[k] = logistic_at(-32768 + ((2 * k + 1) * 32768) / LUT_DEPTH);
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_state();
      test_loads_and_clamped_difference();
      test_saturation();
      test_gain_extremes();
      test_random_traffic();
      req_chan.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_elo_rating_update OK");
      end else begin
         $display("tb_elo_rating_update NOT OK");
      end
      $finish;
   end

endmodule
